// ===== src/ped_pkg.sv =====
// ----------------------------------------------------------------------------
// ped_pkg: shared types and constants of the packet exchange device
// Item structs, request kinds, register map and read-data select codes.
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam int BUF_WORDS_DEFAULT = 512;

    // Item kinds carried in req_type
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_RX    = 2'd2,
        REQ_PULL  = 2'd3
    } req_kind_t;

    // Register map (byte offsets)
    localparam logic [19:0] WIN_MASK  = 20'hFF000;
    localparam logic [19:0] A_RX_CTRL = 20'h00000;
    localparam logic [19:0] A_RX_SIZE = 20'h00004;
    localparam logic [19:0] A_TX_CTRL = 20'h00008;
    localparam logic [19:0] A_TX_SIZE = 20'h0000C;
    localparam logic [19:0] A_RX_WIN  = 20'h01000;
    localparam logic [19:0] A_TX_WIN  = 20'h02000;

    // Window word index width: offset bits [11:2]
    localparam int IDX_W = 10;

    // Control register bits
    localparam int CTRL_RELEASE = 0;
    localparam int CTRL_IEN     = 1;

    // Which buffer supplies data to a result in the read stage
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_RX   = 2'd1,
        SRC_TX   = 2'd2
    } src_sel_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [19:0] address;
        logic [31:0] wdata;
        logic [31:0] rx_word;
        logic        rx_last;
    } req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        bus_error;
        logic        rx_irq;
        logic        tx_irq;
        logic        tx_valid;
        logic [31:0] tx_word;
        logic        tx_last;
    } rsp_t;

    // Control register read layout: bit0 ready, bit1 ien, bit3 flag
    function automatic logic [31:0] ctrl_word(logic rdy, logic ien, logic flag);
        ctrl_word = {28'd0, flag, 1'b0, ien, rdy};
    endfunction

endpackage

// ===== src/ped_ram.sv =====
// ----------------------------------------------------------------------------
// ped_ram: single-port packet buffer
// One access per cycle, write or read; read data registered, valid in the cycle after the read.
// ----------------------------------------------------------------------------
module ped_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/packet_exchange_device_regs.sv =====
// ----------------------------------------------------------------------------
// packet_exchange_device_regs: packet mailbox with receive and transmit buffers
// Each item is one bus read, one bus write, one arriving link word or one
// link pull; every item gives exactly one result item. The block takes one
// item per clock unless the output backs up or the reset sweep runs. A
// result passes the read stage (single-port buffer RAM read) and then the
// output register. The pace is set by the buffer RAMs, each of which
// makes at most one access per item. Control state (ready, enable,
// overrun/underrun, counts, transmit position) lives in flops and is
// updated at acceptance, so consecutive items see each other's effects
// without stalls. After reset the block sweeps both buffers to zero, one
// entry per cycle; req_ready stays low until the sweep is done. Register
// map: 0x00000 rx ctrl, 0x00004 rx size (read only), 0x01xxx rx window
// (read only), 0x00008 tx ctrl, 0x0000C tx size (write only), 0x02xxx tx
// window (write only); anything else gives bus_error. Interrupts are
// levels, enable AND ready, as of the end of the item.
// ----------------------------------------------------------------------------
module packet_exchange_device_regs #(
    parameter int BUF_WORDS = ped_pkg::BUF_WORDS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ped_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ped_pkg::rsp_t rsp
);

    import ped_pkg::*;

    localparam int AW = $clog2(BUF_WORDS);
    localparam int CW = $clog2(BUF_WORDS + 1);
    localparam logic [IDX_W:0]  BUF_LIM = (IDX_W + 1)'(BUF_WORDS);
    localparam logic [CW-1:0]   CNT_MAX = CW'(BUF_WORDS);
    localparam logic [AW-1:0]   CLR_END = AW'(BUF_WORDS - 1);

    // Control state
    logic          rx_ready_reg, rx_ready_next;
    logic          rx_overrun_reg, rx_overrun_next;
    logic          rx_ien_reg, rx_ien_next;
    logic [CW-1:0] rx_count_reg, rx_count_next;
    logic [CW-1:0] rx_fill_reg, rx_fill_next;
    logic          rx_in_packet_reg, rx_in_packet_next;
    logic          rx_dropping_reg, rx_dropping_next;
    logic          tx_ready_reg, tx_ready_next;
    logic          tx_underrun_reg, tx_underrun_next;
    logic          tx_ien_reg, tx_ien_next;
    logic [CW-1:0] tx_count_reg, tx_count_next;
    logic          tx_busy_reg, tx_busy_next;
    logic [CW-1:0] tx_pos_reg, tx_pos_next;

    // Clearing sweep
    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    // Read stage and output register
    logic          s1_valid_reg, s1_valid_next;
    rsp_t          s1_rsp_reg, s1_rsp_next;
    src_sel_t      s1_sel_reg, s1_sel_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_rsp_reg, out_rsp_next;

    // Buffer RAM ports
    logic          rx_en, rx_we, tx_en, tx_we;
    logic [AW-1:0] rx_addr, tx_addr;
    logic [31:0]   rx_wdata, tx_wdata, rx_rdata, tx_rdata;

    logic             accept, s1_adv;
    logic [IDX_W-1:0] idx;
    logic             idx_ok, rx_win, tx_win;
    logic             drop_eff, rx_store_ok;
    logic [CW-1:0]    fill_eff, fill_inc, pos_inc;

    ped_ram #(.DEPTH(BUF_WORDS), .WIDTH(32)) u_rx_ram (
        .clk   (clk),
        .en    (rx_en),
        .we    (rx_we),
        .addr  (rx_addr),
        .wdata (rx_wdata),
        .rdata (rx_rdata)
    );

    ped_ram #(.DEPTH(BUF_WORDS), .WIDTH(32)) u_tx_ram (
        .clk   (clk),
        .en    (tx_en),
        .we    (tx_we),
        .addr  (tx_addr),
        .wdata (tx_wdata),
        .rdata (tx_rdata)
    );

    // The read stage advances when the output register is free or drains
    assign s1_adv    = !out_valid_reg || rsp_ready;
    assign req_ready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign accept    = req_valid && req_ready;

    assign idx      = req.address[11:2];
    assign idx_ok   = {1'b0, idx} < BUF_LIM;
    assign rx_win   = (req.address & WIN_MASK) == A_RX_WIN;
    assign tx_win   = (req.address & WIN_MASK) == A_TX_WIN;

    // Packet start: restart fill and decide on drop from the ready flag
    assign drop_eff    = rx_in_packet_reg ? rx_dropping_reg : rx_ready_reg;
    assign fill_eff    = rx_in_packet_reg ? rx_fill_reg : '0;
    assign fill_inc    = fill_eff + CW'(1);
    assign rx_store_ok = !drop_eff && (fill_eff < CNT_MAX);
    assign pos_inc     = tx_pos_reg + CW'(1);

    always_comb
    begin
        rx_ready_next     = rx_ready_reg;
        rx_overrun_next   = rx_overrun_reg;
        rx_ien_next       = rx_ien_reg;
        rx_count_next     = rx_count_reg;
        rx_fill_next      = rx_fill_reg;
        rx_in_packet_next = rx_in_packet_reg;
        rx_dropping_next  = rx_dropping_reg;
        tx_ready_next     = tx_ready_reg;
        tx_underrun_next  = tx_underrun_reg;
        tx_ien_next       = tx_ien_reg;
        tx_count_next     = tx_count_reg;
        tx_busy_next      = tx_busy_reg;
        tx_pos_next       = tx_pos_reg;
        clr_active_next   = clr_active_reg;
        clr_addr_next     = clr_addr_reg;

        rx_en    = 1'b0;
        rx_we    = 1'b0;
        rx_addr  = '0;
        rx_wdata = '0;
        tx_en    = 1'b0;
        tx_we    = 1'b0;
        tx_addr  = '0;
        tx_wdata = '0;

        s1_rsp_next = '0;
        s1_sel_next = SRC_NONE;

        if (clr_active_reg)
        begin
            // Zero one entry of each buffer per cycle
            rx_en   = 1'b1;
            rx_we   = 1'b1;
            rx_addr = clr_addr_reg;
            tx_en   = 1'b1;
            tx_we   = 1'b1;
            tx_addr = clr_addr_reg;
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == CLR_END)
            begin
                clr_active_next = 1'b0;
            end
        end
        else if (accept)
        begin
            unique case (req_kind_t'(req.req_type))
                REQ_READ:
                begin
                    priority if (req.address == A_RX_CTRL)
                    begin
                        s1_rsp_next.rdata = ctrl_word(rx_ready_reg, rx_ien_reg,
                                                      rx_overrun_reg);
                    end
                    else if (req.address == A_RX_SIZE)
                    begin
                        s1_rsp_next.rdata = 32'(rx_count_reg);
                    end
                    else if (rx_win)
                    begin
                        // Out-of-range window word reads as zero
                        if (idx_ok)
                        begin
                            rx_en       = 1'b1;
                            rx_addr     = idx[AW-1:0];
                            s1_sel_next = SRC_RX;
                        end
                    end
                    else if (req.address == A_TX_CTRL)
                    begin
                        s1_rsp_next.rdata = ctrl_word(tx_ready_reg, tx_ien_reg,
                                                      tx_underrun_reg);
                    end
                    else
                    begin
                        s1_rsp_next.bus_error = 1'b1;
                    end
                end
                REQ_WRITE:
                begin
                    priority if (req.address == A_RX_CTRL)
                    begin
                        if (req.wdata[CTRL_RELEASE])
                        begin
                            rx_ready_next   = 1'b0;
                            rx_overrun_next = 1'b0;
                        end
                        rx_ien_next = req.wdata[CTRL_IEN];
                    end
                    else if (req.address == A_RX_SIZE || rx_win)
                    begin
                        s1_rsp_next.bus_error = 1'b1;
                    end
                    else if (req.address == A_TX_CTRL)
                    begin
                        if (req.wdata[CTRL_RELEASE])
                        begin
                            tx_ready_next    = 1'b0;
                            tx_underrun_next = 1'b0;
                            tx_busy_next     = 1'b1;
                            tx_pos_next      = '0;
                        end
                        tx_ien_next = req.wdata[CTRL_IEN];
                    end
                    else if (req.address == A_TX_SIZE)
                    begin
                        tx_count_next = (req.wdata > 32'(BUF_WORDS)) ? CNT_MAX
                                                                     : req.wdata[CW-1:0];
                    end
                    else if (tx_win)
                    begin
                        // Drop writes beyond the buffer
                        if (idx_ok)
                        begin
                            tx_en    = 1'b1;
                            tx_we    = 1'b1;
                            tx_addr  = idx[AW-1:0];
                            tx_wdata = req.wdata;
                        end
                    end
                    else
                    begin
                        s1_rsp_next.bus_error = 1'b1;
                    end
                end
                REQ_RX:
                begin
                    if (!rx_in_packet_reg && rx_ready_reg)
                    begin
                        rx_overrun_next = 1'b1;
                    end
                    rx_fill_next = fill_eff;
                    if (rx_store_ok)
                    begin
                        rx_en        = 1'b1;
                        rx_we        = 1'b1;
                        rx_addr      = fill_eff[AW-1:0];
                        rx_wdata     = req.rx_word;
                        rx_fill_next = fill_inc;
                    end
                    if (req.rx_last)
                    begin
                        if (!drop_eff)
                        begin
                            rx_count_next = rx_store_ok ? fill_inc : fill_eff;
                            rx_ready_next = 1'b1;
                        end
                        rx_in_packet_next = 1'b0;
                        rx_dropping_next  = 1'b0;
                    end
                    else
                    begin
                        rx_in_packet_next = 1'b1;
                        rx_dropping_next  = drop_eff;
                    end
                end
                REQ_PULL:
                begin
                    if (tx_busy_reg)
                    begin
                        if (tx_pos_reg < tx_count_reg)
                        begin
                            tx_en                = 1'b1;
                            tx_addr              = tx_pos_reg[AW-1:0];
                            s1_sel_next          = SRC_TX;
                            s1_rsp_next.tx_valid = 1'b1;
                            tx_pos_next          = pos_inc;
                            if (!(pos_inc < tx_count_reg))
                            begin
                                s1_rsp_next.tx_last = 1'b1;
                                tx_busy_next        = 1'b0;
                                tx_ready_next       = 1'b1;
                                tx_underrun_next    = 1'b1;
                            end
                        end
                        else
                        begin
                            // Empty packet: complete without a word
                            tx_busy_next     = 1'b0;
                            tx_ready_next    = 1'b1;
                            tx_underrun_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        s1_rsp_next.rx_irq = rx_ien_next && rx_ready_next;
        s1_rsp_next.tx_irq = tx_ien_next && tx_ready_next;
    end

    // Pipeline occupancy and merge of RAM read data
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_rsp_next   = out_rsp_reg;

        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_valid_next = 1'b1;
            out_rsp_next   = s1_rsp_reg;
            unique case (s1_sel_reg)
                SRC_RX:   out_rsp_next.rdata   = rx_rdata;
                SRC_TX:   out_rsp_next.tx_word = tx_rdata;
                default:
                begin
                end
            endcase
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ready_reg     <= 1'b0;
            rx_overrun_reg   <= 1'b0;
            rx_ien_reg       <= 1'b0;
            rx_count_reg     <= '0;
            rx_fill_reg      <= '0;
            rx_in_packet_reg <= 1'b0;
            rx_dropping_reg  <= 1'b0;
            tx_ready_reg     <= 1'b1;
            tx_underrun_reg  <= 1'b1;
            tx_ien_reg       <= 1'b0;
            tx_count_reg     <= '0;
            tx_busy_reg      <= 1'b0;
            tx_pos_reg       <= '0;
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rx_ready_reg     <= rx_ready_next;
            rx_overrun_reg   <= rx_overrun_next;
            rx_ien_reg       <= rx_ien_next;
            rx_count_reg     <= rx_count_next;
            rx_fill_reg      <= rx_fill_next;
            rx_in_packet_reg <= rx_in_packet_next;
            rx_dropping_reg  <= rx_dropping_next;
            tx_ready_reg     <= tx_ready_next;
            tx_underrun_reg  <= tx_underrun_next;
            tx_ien_reg       <= tx_ien_next;
            tx_count_reg     <= tx_count_next;
            tx_busy_reg      <= tx_busy_next;
            tx_pos_reg       <= tx_pos_next;
            clr_active_reg   <= clr_active_next;
            clr_addr_reg     <= clr_addr_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload: load only on accept or advance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rsp_reg <= s1_rsp_next;
            s1_sel_reg <= s1_sel_next;
        end
        out_rsp_reg <= out_rsp_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

endmodule
